[hdl/aenc_pkg.sv]
// shared types and constants of the arithmetic encoder
package aenc_pkg;

    // default code register width
    localparam int CODE_BITS_DEF = 32;
    // width of the interval fields
    localparam int CUM_W = 29;
    // width of the pending underflow counter
    localparam int FOLLOW_W = 32;
    // most results one encode transaction may produce
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_CALC,
        S_EMIT,
        S_UNDER
    } t_state;

    // shared divide / multiply unit
    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_MUL,
        A_DONE
    } t_arith_state;

endpackage

[hdl/arithmetic_encoder_top.sv]
// Encode: a serial divide and 29 multiply steps narrow the range, then results follow at one
// per cycle while the output is taken; up to 32 results and up to CODE_BITS underflow rescales
// come before the next transaction is taken, and output stalls hold it back further.
// Finish and rejected intervals give a single result before the next accept.
// Sync active-low reset: range [0, 1 << (CODE_BITS-1)), pending count zero, no held result.
module arithmetic_encoder_top
    import aenc_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [CUM_W-1:0]    i_cum_low,
    input  logic [CUM_W-1:0]    i_cum_high,
    input  logic [CUM_W-1:0]    i_total,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_lead_bit,
    output logic [FOLLOW_W-1:0] o_follow_count,
    output logic                o_is_last,
    output logic                o_bad_request
);

    localparam int CMP_W = (CODE_BITS > CUM_W) ? CODE_BITS : CUM_W;
    localparam int GUARD_W = $clog2(CODE_BITS + 1);
    localparam logic [CODE_BITS-1:0] ONE = {{(CODE_BITS-1){1'b0}}, 1'b1};
    localparam logic [CODE_BITS-1:0] QUARTER = ONE << (CODE_BITS - 3);
    localparam logic [CODE_BITS-1:0] HALF = ONE << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] THREEQ = QUARTER | HALF;
    localparam logic [CODE_BITS-1:0] FULL = ONE << (CODE_BITS - 1);
    localparam logic [CMP_W-1:0] DENOM_LIMIT =
        ({{(CMP_W-1){1'b0}}, 1'b1} << (CODE_BITS - 3)) - 1'b1;

    t_state r_state, n_state;
    logic [CODE_BITS-1:0] r_low, n_low;
    logic [CODE_BITS-1:0] r_high, n_high;
    logic [FOLLOW_W-1:0]  r_pend, n_pend;
    logic [NRES_W-1:0]    r_nres, n_nres;
    logic [GUARD_W-1:0]   r_guard, n_guard;
    logic                 r_one_bad, n_one_bad;
    logic                 r_out_valid, n_out_valid;
    logic                 r_lead, n_lead;
    logic [FOLLOW_W-1:0]  r_follow, n_follow;
    logic                 r_last, n_last;
    logic                 r_bad, n_bad;

    logic                 in_acc;
    logic                 out_free;
    logic                 req_ok;
    logic                 arith_start;
    logic                 arith_done;
    logic [CODE_BITS-1:0] arith_low;
    logic [CODE_BITS-1:0] arith_high;
    logic                 emit_zero;
    logic                 emit_one;
    logic [CODE_BITS-1:0] emit_base;
    logic [CODE_BITS-1:0] emit_low;
    logic [CODE_BITS-1:0] emit_high;
    logic [CODE_BITS-1:0] uf_low;
    logic [CODE_BITS-1:0] uf_high;
    logic [NRES_W-1:0]    nres_inc;
    logic                 more_after;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // interval check: cum_low < cum_high <= total <= limit
    assign req_ok = (i_cum_low < i_cum_high) && (i_cum_high <= i_total)
                 && (CMP_W'(i_total) <= DENOM_LIMIT);

    assign arith_start = in_acc && (i_operation == OP_ENCODE) && req_ok;

    aenc_arith #(
        .CODE_BITS(CODE_BITS)
    ) u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (arith_start),
        .i_span     (r_high - r_low),
        .i_base     (r_low),
        .i_divisor  (i_total),
        .i_cum_low  (i_cum_low),
        .i_cum_high (i_cum_high),
        .o_done     (arith_done),
        .o_new_low  (arith_low),
        .o_new_high (arith_high)
    );

    // renormalization: decided top bit and the window after doubling
    assign emit_zero  = (r_nres != NRES_W'(MAX_RESULTS)) && (r_high <= HALF);
    assign emit_one   = (r_nres != NRES_W'(MAX_RESULTS)) && !emit_zero && (r_low >= HALF);
    assign emit_base  = emit_zero ? '0 : HALF;
    assign emit_low   = (r_low - emit_base) << 1;
    assign emit_high  = (r_high - emit_base) << 1;
    assign nres_inc   = r_nres + 1'b1;
    assign more_after = (nres_inc != NRES_W'(MAX_RESULTS))
                     && ((emit_high <= HALF) || (emit_low >= HALF));

    // middle-half rescale
    assign uf_low  = (r_low - QUARTER) << 1;
    assign uf_high = (r_high - QUARTER) << 1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low       <= '0;
            r_high      <= FULL;
            r_pend      <= '0;
            r_nres      <= '0;
            r_guard     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_high      <= n_high;
            r_pend      <= n_pend;
            r_nres      <= n_nres;
            r_guard     <= n_guard;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_one_bad <= n_one_bad;
        r_lead    <= n_lead;
        r_follow  <= n_follow;
        r_last    <= n_last;
        r_bad     <= n_bad;
    end

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_pend      = r_pend;
        n_nres      = r_nres;
        n_guard     = r_guard;
        n_one_bad   = r_one_bad;
        n_out_valid = r_out_valid && !i_out_ready;
        n_lead      = r_lead;
        n_follow    = r_follow;
        n_last      = r_last;
        n_bad       = r_bad;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == OP_FINISH) begin
                        n_one_bad = 1'b0;
                        n_state   = S_ONE;
                    end else if (!req_ok) begin
                        n_one_bad = 1'b1;
                        n_state   = S_ONE;
                    end else begin
                        n_state = S_CALC;
                    end
                end
            end
            S_ONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_lead      = !r_one_bad;
                    n_follow    = '0;
                    n_last      = 1'b1;
                    n_bad       = r_one_bad;
                    n_state     = S_IDLE;
                end
            end
            S_CALC: begin
                if (arith_done) begin
                    n_low   = arith_low;
                    n_high  = arith_high;
                    n_nres  = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_zero || emit_one) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_lead      = emit_one;
                        n_follow    = r_pend;
                        n_last      = !more_after;
                        n_bad       = 1'b0;
                        n_pend      = '0;
                        n_low       = emit_low;
                        n_high      = emit_high;
                        n_nres      = nres_inc;
                    end
                end else begin
                    n_guard = '0;
                    n_state = S_UNDER;
                end
            end
            S_UNDER: begin
                if ((r_guard != GUARD_W'(CODE_BITS)) && (r_low >= QUARTER)
                        && (r_high <= THREEQ)) begin
                    n_low   = uf_low;
                    n_high  = uf_high;
                    n_guard = r_guard + 1'b1;
                    if (r_pend != '1) begin
                        n_pend = r_pend + 1'b1;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_lead_bit     = r_lead;
    assign o_follow_count = r_follow;
    assign o_is_last      = r_last;
    assign o_bad_request  = r_bad;

endmodule

[hdl/aenc_arith.sv]
// serial divider and shift-add multiplier that narrow the coding range
module aenc_arith
    import aenc_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CODE_BITS-1:0] i_span,
    input  logic [CODE_BITS-1:0] i_base,
    input  logic [CUM_W-1:0]     i_divisor,
    input  logic [CUM_W-1:0]     i_cum_low,
    input  logic [CUM_W-1:0]     i_cum_high,
    output logic                 o_done,
    output logic [CODE_BITS-1:0] o_new_low,
    output logic [CODE_BITS-1:0] o_new_high
);

    localparam int STEPS_MAX = (CODE_BITS > CUM_W) ? CODE_BITS : CUM_W;
    localparam int CNT_W = $clog2(STEPS_MAX + 1);

    t_arith_state r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CODE_BITS-1:0] r_quo, n_quo;
    logic [CUM_W-1:0]     r_rem, n_rem;
    logic [CUM_W-1:0]     r_div, n_div;
    logic [CUM_W-1:0]     r_lo_m, n_lo_m;
    logic [CUM_W-1:0]     r_hi_m, n_hi_m;
    logic [CODE_BITS-1:0] r_base, n_base;
    logic [CODE_BITS-1:0] r_mcand, n_mcand;
    logic [CODE_BITS-1:0] r_acc_lo, n_acc_lo;
    logic [CODE_BITS-1:0] r_acc_hi, n_acc_hi;

    logic [CUM_W:0]       rem_sh;
    logic                 rem_ge;
    logic [CUM_W:0]       rem_sub;

    // restoring division step, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quo[CODE_BITS-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_lo_m   <= n_lo_m;
        r_hi_m   <= n_hi_m;
        r_base   <= n_base;
        r_mcand  <= n_mcand;
        r_acc_lo <= n_acc_lo;
        r_acc_hi <= n_acc_hi;
    end

    // sequencer: divide, then both products side by side
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_lo_m   = r_lo_m;
        n_hi_m   = r_hi_m;
        n_base   = r_base;
        n_mcand  = r_mcand;
        n_acc_lo = r_acc_lo;
        n_acc_hi = r_acc_hi;
        case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    n_state = A_DIV;
                    n_cnt   = '0;
                    n_quo   = i_span;
                    n_rem   = '0;
                    n_div   = i_divisor;
                    n_lo_m  = i_cum_low;
                    n_hi_m  = i_cum_high;
                    n_base  = i_base;
                end
            end
            A_DIV: begin
                n_quo = {r_quo[CODE_BITS-2:0], rem_ge};
                n_rem = rem_ge ? rem_sub[CUM_W-1:0] : rem_sh[CUM_W-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CODE_BITS - 1)) begin
                    n_state  = A_MUL;
                    n_cnt    = '0;
                    n_mcand  = {r_quo[CODE_BITS-2:0], rem_ge};
                    n_acc_lo = r_base;
                    n_acc_hi = r_base;
                end
            end
            A_MUL: begin
                n_acc_lo = r_acc_lo + (r_lo_m[0] ? r_mcand : '0);
                n_acc_hi = r_acc_hi + (r_hi_m[0] ? r_mcand : '0);
                n_mcand  = {r_mcand[CODE_BITS-2:0], 1'b0};
                n_lo_m   = {1'b0, r_lo_m[CUM_W-1:1]};
                n_hi_m   = {1'b0, r_hi_m[CUM_W-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CUM_W - 1)) begin
                    n_state = A_DONE;
                end
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    assign o_done     = (r_state == A_DONE);
    assign o_new_low  = r_acc_lo;
    assign o_new_high = r_acc_hi;

endmodule

[hdl/aenc_checker.sv]
// port-level checks of the arithmetic encoder, bound to the top level
module aenc_checker
    import aenc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                i_operation,
    input logic [CUM_W-1:0]    i_cum_low,
    input logic [CUM_W-1:0]    i_cum_high,
    input logic [CUM_W-1:0]    i_total,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_lead_bit,
    input logic [FOLLOW_W-1:0] o_follow_count,
    input logic                o_is_last,
    input logic                o_bad_request
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_lead_bit)
            && $stable(o_follow_count) && $stable(o_is_last))
        else $error("result changed while stalled");

    // reset leaves no result showing
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a rejected interval is a lone, final zero result
    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_request |-> o_is_last && !o_lead_bit
            && (o_follow_count == '0))
        else $error("malformed rejection result");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // finish result carries a one and no pending bits
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == OP_FINISH) && !o_out_valid
            |=> ##1 o_out_valid && o_lead_bit && o_is_last && !o_bad_request
            && (o_follow_count == '0))
        else $error("finish result wrong");

endmodule

bind arithmetic_encoder_top aenc_checker u_aenc_checker (.*);
